>>> rtl/amav_pkg.sv
// ----------------------------------------------------------------------------
// amav_pkg
// Shared widths, constants and register map of the converter moving-average
// filter.
// ----------------------------------------------------------------------------
package amav_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned MV_W      = 16;
    localparam int unsigned PROD_W    = SAMPLE_W + MV_W;

    // Converter full-scale code, the divisor of the millivolt scaling
    localparam logic [SAMPLE_W-1:0] ADC_FULL_CODE = 12'd4095;

    // Register reset values
    localparam logic [MV_W-1:0] FULL_SCALE_RESET = 16'd3300;

    // Default depth of the averaging window
    localparam int unsigned WINDOW_DEF = 20;

    // Register map: word index taken from paddr above the byte offset
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 1'b0;

endpackage

>>> rtl/amav_scale.sv
// ----------------------------------------------------------------------------
// amav_scale
// Three-stage pipeline that converts a raw sample to millivolts:
// sample * full_scale, then a truncating divide by 4095 done as a
// shift-and-add estimate followed by a single correction step.
// ----------------------------------------------------------------------------
module amav_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [amav_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [amav_pkg::MV_W-1:0]     i_full_scale,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [amav_pkg::MV_W-1:0]     o_scaled
);

    localparam int unsigned PW = amav_pkg::PROD_W;
    localparam int unsigned MW = amav_pkg::MV_W;

    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_prod2;
    logic [MW-1:0] r_q0;
    logic [MW-1:0] r_scaled;

    logic          w_rdy1;
    logic          w_rdy2;
    logic          w_rdy3;
    logic [PW:0]   w_est;
    logic [PW-1:0] w_rem;
    logic [MW-1:0] n_scaled;

    // A stage takes a new word when it is empty or its word moves on
    assign w_rdy3  = !r_v3 || !i_stall;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r_v3;
    assign o_scaled = r_scaled;

    // x/4095 = x/4096 * (1 + 2^-12 + 2^-24 + ...); the estimate is low by at most one
    assign w_est = (PW+1)'(r_prod) + (PW+1)'(r_prod[PW-1:12]) + (PW+1)'(r_prod[PW-1:24]);

    // Remainder x - q0*4095, below twice the divisor
    assign w_rem = r_prod2 + PW'(r_q0) - {r_q0, 12'b0};

    // Bump the estimate when the remainder reaches the divisor
    always_comb begin
        if (w_rem >= PW'(amav_pkg::ADC_FULL_CODE)) begin
            n_scaled = r_q0 + MW'(1);
        end else begin
            n_scaled = r_q0;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Datapath: product, quotient estimate, corrected quotient
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_prod <= PW'(i_sample) * PW'(i_full_scale);
        end
        if (w_rdy2 && r_v1) begin
            r_q0    <= w_est[PW-1:12];
            r_prod2 <= r_prod;
        end
        if (w_rdy3 && r_v2) begin
            r_scaled <= n_scaled;
        end
    end

endmodule

>>> rtl/adc_moving_average_mv_top.sv
// ----------------------------------------------------------------------------
// adc_moving_average_mv_top
// Moving-average filter for a 12-bit converter with results in millivolts.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   sample   | in        | i_valid / o_stall  | i_adc_sample
//   result   | out       | o_valid / i_stall  | o_filtered_mv, o_scaled_mv
//   config   | in        | APB psel / penable | full_scale_mv at byte 0
//
// One sample is taken every cycle while o_stall is low. Its result word
// passes six registers in order: the input register, the 12x16 multiplier,
// the divide-by-4095 estimate, its correction, the reciprocal multiplier
// for the window divide, and the running-sum output register.
// Reset clears the whole window at once.
// Each stage holds its word while the next one is full and stalled, so
// empty stages still accept words behind a stalled output.
// ----------------------------------------------------------------------------
module adc_moving_average_mv_top #(
    parameter int unsigned WINDOW = amav_pkg::WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [amav_pkg::SAMPLE_W-1:0]    i_adc_sample,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [amav_pkg::MV_W-1:0]        o_filtered_mv,
    output logic [amav_pkg::MV_W-1:0]        o_scaled_mv,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [amav_pkg::PADDR_W-1:0]     paddr,
    input  logic [amav_pkg::PDATA_W-1:0]     pwdata,
    output logic [amav_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int unsigned MW          = amav_pkg::MV_W;
    localparam int unsigned WIN_LOG     = $clog2(WINDOW);
    // Each quotient is below 2^(17 - log2 ceiling of the window)
    localparam int unsigned QUOT_W      = MW + 1 - WIN_LOG;
    localparam int unsigned RECIP_SHIFT = MW + WIN_LOG;
    localparam int unsigned RECIP_W     = MW + 2;
    localparam int unsigned PRODQ_W     = MW + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'((64'd1 << RECIP_SHIFT) / WINDOW + 64'd1);

    logic [MW-1:0]                   r_full_scale;
    logic                            r_v0;
    logic [amav_pkg::SAMPLE_W-1:0]   r_sample;
    logic                            r_v4;
    logic [QUOT_W-1:0]               r_s4_quot;
    logic [MW-1:0]                   r_s4_scaled;
    logic                            r_v5;
    logic [MW-1:0]                   r_out_filtered;
    logic [MW-1:0]                   r_out_scaled;
    logic [MW-1:0]                   r_sum;
    logic [QUOT_W-1:0]               r_win [WINDOW];

    logic                            w_cfg_wr;
    logic                            w_rdy0;
    logic                            w_rdy4;
    logic                            w_rdy5;
    logic                            w_scale_stall;
    logic                            w_scale_valid;
    logic [MW-1:0]                   w_scaled;
    logic [PRODQ_W-1:0]              w_prod_q;
    logic [MW-1:0]                   n_sum;

    // Configuration access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite &&
                      (paddr[amav_pkg::PADDR_W-1:2] == amav_pkg::REG_FULL_SCALE);

    always_comb begin
        if (paddr[amav_pkg::PADDR_W-1:2] == amav_pkg::REG_FULL_SCALE) begin
            prdata = amav_pkg::PDATA_W'(r_full_scale);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= amav_pkg::FULL_SCALE_RESET;
        end else if (w_cfg_wr) begin
            r_full_scale <= pwdata[MW-1:0];
        end
    end

    // Stage readiness, from the output back to the input
    assign w_rdy5  = !r_v5 || !i_stall;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy0  = !r_v0 || !w_scale_stall;
    assign o_stall = !w_rdy0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_rdy0) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_sample <= i_adc_sample;
        end
    end

    // Millivolt scaling pipeline
    amav_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_v0),
        .o_stall      (w_scale_stall),
        .i_sample     (r_sample),
        .i_full_scale (r_full_scale),
        .o_valid      (w_scale_valid),
        .i_stall      (!w_rdy4),
        .o_scaled     (w_scaled)
    );

    // Divide by the window depth through an exact reciprocal multiply
    assign w_prod_q = PRODQ_W'(w_scaled) * PRODQ_W'(RECIP_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= w_scale_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && w_scale_valid) begin
            r_s4_quot   <= w_prod_q[RECIP_SHIFT +: QUOT_W];
            r_s4_scaled <= w_scaled;
        end
    end

    // Add the newest quotient, drop the oldest
    assign n_sum = r_sum + MW'(r_s4_quot) - MW'(r_win[WINDOW-1]);

    // Window shift line, running sum and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5  <= 1'b0;
            r_sum <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_rdy5) begin
            r_v5 <= r_v4;
            if (r_v4) begin
                r_sum    <= n_sum;
                r_win[0] <= r_s4_quot;
                for (int i = 1; i < WINDOW; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r_out_filtered <= n_sum;
            r_out_scaled   <= r_s4_scaled;
        end
    end

    assign o_valid       = r_v5;
    assign o_filtered_mv = r_out_filtered;
    assign o_scaled_mv   = r_out_scaled;

endmodule

>>> rtl/amav_checker.sv
// ----------------------------------------------------------------------------
// amav_assertions
// Port-level checks of the moving-average filter: reset, output hold,
// stall release and pipeline latency.
// ----------------------------------------------------------------------------
module amav_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [amav_pkg::MV_W-1:0]     o_filtered_mv,
    input logic [amav_pkg::MV_W-1:0]     o_scaled_mv
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_filtered_mv) && $stable(o_scaled_mv)))
        else $error("stalled result changed");

    // With the output free to drain, never push back on samples
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output can drain");

    // An accepted sample reaches the output while the output is not stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
            ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("result missing after pipeline latency");

endmodule

bind adc_moving_average_mv_top amav_assertions u_amav_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_filtered_mv (o_filtered_mv),
    .o_scaled_mv   (o_scaled_mv)
);
